// ===== rtl/rip_pkg.sv =====
// shared types and constants for the ratio interleave pattern block
`timescale 1ns / 1ps
package rip_pkg;

	localparam int ID_W   = 8;
	localparam int PCT_W  = 7;
	localparam int SLOT_W = 7;
	localparam int CYC_W  = 7;
	localparam int PROD_W = SLOT_W + CYC_W;
	localparam int REM_W  = CYC_W + 1;
	localparam int STEP_N = 7;
	localparam int PCT_N  = 1 << PCT_W;
	localparam int FULL_PCT = 100;

	// payload carried through the remainder stages
	typedef struct packed {
		logic              ok;
		logic [ID_W-1:0]   id_a;
		logic [ID_W-1:0]   id_b;
		logic [CYC_W-1:0]  cyc;
		logic [CYC_W-1:0]  rb;
		logic [PROD_W-1:0] prod;
		logic [CYC_W-1:0]  rem;
	} rip_work_t;

endpackage

// ===== rtl/rip_ratio_lut.sv =====
// per-percentage ratio table: share of b and cycle length, with and without the cap
`timescale 1ns / 1ps
module rip_ratio_lut import rip_pkg::*; #(
	parameter int CYCLE_CAP = 24
) (
	input  logic [PCT_W-1:0] pct,
	input  logic             cap,
	output logic [CYC_W-1:0] rb,
	output logic [CYC_W-1:0] cyc
);

	logic [CYC_W-1:0] rb_u [PCT_N];
	logic [CYC_W-1:0] cyc_u [PCT_N];
	logic [CYC_W-1:0] rb_c [PCT_N];
	logic [CYC_W-1:0] cyc_c [PCT_N];

	// table entries worked out at elaboration
	for (genvar p = 0; p < PCT_N; p++) begin : g_tab
		localparam int PB    = (p > FULL_PCT) ? FULL_PCT : p;
		localparam int PA    = FULL_PCT - PB;
		localparam bit BMAJ  = (PB >= PA);
		localparam int MAJ   = BMAJ ? PB : PA;
		localparam int MIN0  = BMAJ ? PA : PB;
		localparam int MINV  = (MIN0 == 0) ? 1 : MIN0;
		localparam int NV0   = (2 * MAJ + MINV) / (2 * MINV);
		localparam int NV    = (NV0 < 1) ? 1 : NV0;
		localparam int RA    = (PB == 0) ? 1 : ((PB >= FULL_PCT) ? 0 : (BMAJ ? 1 : NV));
		localparam int RB    = (PB == 0) ? 0 : ((PB >= FULL_PCT) ? 1 : (BMAJ ? NV : 1));
		localparam int S     = RA + RB;
		localparam bit DOCAP = (RA > 0) && (RB > 0) && (S > CYCLE_CAP);
		localparam int CA0   = (2 * RA * CYCLE_CAP + S) / (2 * S);
		localparam int CB0   = (2 * RB * CYCLE_CAP + S) / (2 * S);
		localparam int CA    = DOCAP ? ((CA0 < 1) ? 1 : CA0) : RA;
		localparam int CB    = DOCAP ? ((CB0 < 1) ? 1 : CB0) : RB;
		assign rb_u[p]  = CYC_W'(RB);
		assign cyc_u[p] = CYC_W'(S);
		assign rb_c[p]  = CYC_W'(CB);
		assign cyc_c[p] = CYC_W'(CA + CB);
	end

	// select capped or plain entry
	always_comb begin
		rb  = cap ? rb_c[pct] : rb_u[pct];
		cyc = cap ? cyc_c[pct] : cyc_u[pct];
	end

endmodule

// ===== rtl/rip_rem_stage.sv =====
// seven restoring remainder steps on the top product bits, then a register
`timescale 1ns / 1ps
module rip_rem_stage import rip_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_in,
	input  rip_work_t d,
	output logic      vld_out,
	output rip_work_t q
);

	rip_work_t nxt;
	logic      vld_q;
	rip_work_t work_q;

	// shift in one product bit per step, subtract the cycle when it fits
	always_comb begin
		logic [REM_W-1:0] r;
		nxt = d;
		r   = REM_W'(d.rem);
		for (int i = 0; i < STEP_N; i++) begin
			r = {r[REM_W-2:0], d.prod[PROD_W-1-i]};
			if (r >= REM_W'(d.cyc)) begin
				r = r - REM_W'(d.cyc);
			end
		end
		nxt.rem  = r[CYC_W-1:0];
		nxt.prod = d.prod << STEP_N;
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign q       = work_q;

endmodule

// ===== rtl/ratio_interleave_pattern_top.sv =====
// top level of the ratio interleave pattern query pipeline
`timescale 1ns / 1ps
// Answers one pattern query per clock unless stalled: which of two component ids sits at
// a given position of a 1:N interleave cycle, or its capped form, derived from a percentage
// of B, and how long that cycle is. A query passes through a table stage, a multiply stage,
// two remainder stages and an output register; the pipeline moves as one and halts only
// while a finished result is held and not taken.
module ratio_interleave_pattern_top import rip_pkg::*; #(
	parameter int CYCLE_CAP = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ID_W-1:0]   first_id,
	input  logic [ID_W-1:0]   second_id,
	input  logic [PCT_W-1:0]  share_b,
	input  logic              cap_cycle,
	input  logic [SLOT_W-1:0] slot,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ID_W-1:0]   chosen_id,
	output logic [CYC_W-1:0]  cycle_len,
	output logic              ok
);

	logic              en;
	logic [CYC_W-1:0]  lut_rb;
	logic [CYC_W-1:0]  lut_cyc;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              idok_s1;
	logic [ID_W-1:0]   ida_s1, idb_s1;
	logic [CYC_W-1:0]  rb_s1, cyc_s1;
	logic [SLOT_W-1:0] slot_s1;
	rip_work_t         w_s2, w_s3, w_s4;
	logic [ID_W-1:0]   chosen_s5;
	logic [CYC_W-1:0]  cyc_s5;
	logic              ok_s5;
	logic [REM_W-1:0]  rsum;

	// whole pipeline advances unless the output holds an untaken result
	assign en       = !v_s5 || out_ready;
	assign in_ready = en;

	rip_ratio_lut #(.CYCLE_CAP(CYCLE_CAP)) u_lut (
		.pct (share_b),
		.cap (cap_cycle),
		.rb  (lut_rb),
		.cyc (lut_cyc)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s5 <= v_s4;
		end
	end

	// stage 1: ratio lookup and id check
	always_ff @(posedge clk) begin
		if (en) begin
			idok_s1 <= (first_id != '0) && (second_id != '0) && (first_id != second_id);
			ida_s1  <= first_id;
			idb_s1  <= second_id;
			rb_s1   <= lut_rb;
			cyc_s1  <= lut_cyc;
			slot_s1 <= slot;
		end
	end

	// stage 2: slot times b share, range check
	always_ff @(posedge clk) begin
		if (en) begin
			w_s2.ok   <= idok_s1 && (slot_s1 < cyc_s1);
			w_s2.id_a <= ida_s1;
			w_s2.id_b <= idb_s1;
			w_s2.cyc  <= idok_s1 ? cyc_s1 : '0;
			w_s2.rb   <= rb_s1;
			w_s2.prod <= PROD_W'(slot_s1) * PROD_W'(rb_s1);
			w_s2.rem  <= '0;
		end
	end

	// stages 3 and 4: remainder of the product by the cycle length
	rip_rem_stage u_rem_hi (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s2),
		.d       (w_s2),
		.vld_out (v_s3),
		.q       (w_s3)
	);

	rip_rem_stage u_rem_lo (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s3),
		.d       (w_s3),
		.vld_out (v_s4),
		.q       (w_s4)
	);

	// b sits here when the remainder plus the b share reaches the cycle
	assign rsum = REM_W'(w_s4.rem) + REM_W'(w_s4.rb);

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5     <= w_s4.ok;
			cyc_s5    <= w_s4.cyc;
			chosen_s5 <= !w_s4.ok ? '0 :
				((rsum >= REM_W'(w_s4.cyc)) ? w_s4.id_b : w_s4.id_a);
		end
	end

	assign out_valid = v_s5;
	assign chosen_id = chosen_s5;
	assign cycle_len = cyc_s5;
	assign ok        = ok_s5;

endmodule
